[hdl/uwbrfp_pkg.sv]
// Package for the UWB report frame parser: byte constants, frame kind codes,
// the per-kind field layout and the structs passed between the submodules.
// No dependencies.
package uwbrfp_pkg;

  localparam int MAX_FRAME_BYTES = 64;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic [7:0] LEN_RANGING = 8'h23;
  localparam logic [7:0] TYPE_RANGING = 8'h37;
  localparam logic [7:0] LEN_NEW_TAG = 8'h08;
  localparam logic [7:0] TYPE_NEW_TAG = 8'h36;
  localparam logic [7:0] LEN_ADD_TAG = 8'h11;
  localparam logic [7:0] TYPE_ADD_TAG = 8'h20;
  localparam logic [7:0] LEN_DEL_TAG = 8'h08;
  localparam logic [7:0] TYPE_DEL_TAG = 8'h21;

  localparam logic [1:0] KIND_RANGING = 2'd0;
  localparam logic [1:0] KIND_NEW_TAG = 2'd1;
  localparam logic [1:0] KIND_ADD_TAG = 2'd2;
  localparam logic [1:0] KIND_DEL_TAG = 2'd3;

  // Position of the first payload byte within a frame.
  localparam logic [5:0] PAYLOAD_START = 6'd3;

  localparam logic STATUS_FIELD = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  // Store write request from the framer.
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } store_wr_t;

  // Frame completion event, raised when the checksum byte is taken.
  typedef struct packed {
    logic       valid;
    logic       good;
    logic [1:0] kind;
    logic [7:0] plen;
  } frame_done_t;

  // Status of the drain side, used by the framer to stall input.
  typedef struct packed {
    logic busy;
    logic out_block;
  } drain_stat_t;

  // Number of decoded fields for a frame kind.
  function automatic logic [3:0] field_count(input logic [1:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_RANGING: n = 4'd12;
      KIND_NEW_TAG: n = 4'd1;
      KIND_ADD_TAG: n = 4'd6;
      default:      n = 4'd1;
    endcase
    return n;
  endfunction

  // Byte size of one field. Fields are contiguous from the first payload
  // byte on, so only sizes are needed.
  function automatic logic [3:0] field_size(input logic [1:0] kind,
                                            input logic [3:0] idx);
    logic [3:0] s;
    s = 4'd1;
    case (kind)
      KIND_RANGING: begin
        case (idx)
          4'd0:                        s = 4'd2;
          4'd1:                        s = 4'd1;
          4'd2, 4'd3, 4'd4, 4'd5,
          4'd6, 4'd7:                  s = 4'd4;
          default:                     s = 4'd2;
        endcase
      end
      KIND_ADD_TAG: begin
        case (idx)
          4'd1:    s = 4'd8;
          4'd5:    s = 4'd1;
          default: s = 4'd2;
        endcase
      end
      default: s = 4'd8;
    endcase
    return s;
  endfunction

endpackage

[hdl/uwbrfp_framer.sv]
// Byte framer of the UWB report frame parser: sync hunt, pair check,
// running checksum and store writes. Depends on uwbrfp_pkg.
module uwbrfp_framer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  input  uwbrfp_pkg::drain_stat_t   stat,
  output uwbrfp_pkg::store_wr_t     wr,
  output uwbrfp_pkg::frame_done_t   done
);

  logic [5:0] byte_position;
  logic [7:0] payload_length;
  logic [1:0] kind_seen;
  logic [7:0] running_sum;

  logic       accept;
  logic       is_chk;
  logic       pair_ok;
  logic [1:0] pair_kind;
  logic [7:0] sum_next;

  // The checksum byte sits right after the payload.
  assign is_chk = (byte_position >= uwbrfp_pkg::PAYLOAD_START) &&
                  ({3'b000, byte_position} >= ({1'b0, payload_length} + 9'd3));

  // A checksum byte makes a result, so it waits for a free output register.
  assign in_stall = stat.busy | (is_chk & stat.out_block);
  assign accept = in_valid & ~in_stall;
  assign sum_next = running_sum + rx_byte;

  always_comb begin
    pair_ok = 1'b1;
    pair_kind = uwbrfp_pkg::KIND_RANGING;
    if (payload_length == uwbrfp_pkg::LEN_RANGING && rx_byte == uwbrfp_pkg::TYPE_RANGING) begin
      pair_kind = uwbrfp_pkg::KIND_RANGING;
    end else if (payload_length == uwbrfp_pkg::LEN_NEW_TAG &&
                 rx_byte == uwbrfp_pkg::TYPE_NEW_TAG) begin
      pair_kind = uwbrfp_pkg::KIND_NEW_TAG;
    end else if (payload_length == uwbrfp_pkg::LEN_ADD_TAG &&
                 rx_byte == uwbrfp_pkg::TYPE_ADD_TAG) begin
      pair_kind = uwbrfp_pkg::KIND_ADD_TAG;
    end else if (payload_length == uwbrfp_pkg::LEN_DEL_TAG &&
                 rx_byte == uwbrfp_pkg::TYPE_DEL_TAG) begin
      pair_kind = uwbrfp_pkg::KIND_DEL_TAG;
    end else begin
      pair_ok = 1'b0;
    end
  end

  always_comb begin
    wr.en = accept & ~is_chk &
            ((byte_position != 6'd0) | (rx_byte == uwbrfp_pkg::SYNC_BYTE));
    wr.addr = byte_position;
    wr.data = rx_byte;
    done.valid = accept & is_chk;
    done.good = (rx_byte == running_sum);
    done.kind = kind_seen;
    done.plen = payload_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 6'd0;
      payload_length <= 8'd0;
      kind_seen <= 2'd0;
      running_sum <= 8'd0;
    end else if (accept) begin
      if (byte_position == 6'd0) begin
        if (rx_byte == uwbrfp_pkg::SYNC_BYTE) begin
          running_sum <= rx_byte;
          byte_position <= 6'd1;
        end
      end else if (byte_position == 6'd1) begin
        payload_length <= rx_byte;
        running_sum <= sum_next;
        byte_position <= 6'd2;
      end else if (byte_position == 6'd2) begin
        if (pair_ok) begin
          kind_seen <= pair_kind;
          running_sum <= sum_next;
          byte_position <= 6'd3;
        end else begin
          byte_position <= 6'd0;
        end
      end else if (!is_chk) begin
        running_sum <= sum_next;
        byte_position <= byte_position + 6'd1;
      end else begin
        byte_position <= 6'd0;
      end
    end
  end

endmodule

[hdl/uwbrfp_store.sv]
// Frame byte store of the UWB report frame parser: one write port and one
// registered read port. Depends on uwbrfp_pkg.
module uwbrfp_store #(
  parameter int MAX_FRAME_BYTES = uwbrfp_pkg::MAX_FRAME_BYTES
) (
  input  logic                  clk,
  input  uwbrfp_pkg::store_wr_t wr,
  input  logic                  rd_en,
  input  logic [5:0]            rd_addr,
  output logic [7:0]            rd_data
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);

  logic [7:0] frame_store [MAX_FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      frame_store[AW'(wr.addr)] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= frame_store[AW'(rd_addr)];
    end
  end

endmodule

[hdl/uwbrfp_drain.sv]
// Field drain of the UWB report frame parser: reads the payload back byte
// by byte, assembles fields and holds the result register.
// Depends on uwbrfp_pkg.
module uwbrfp_drain (
  input  logic                    clk,
  input  logic                    rst,
  input  uwbrfp_pkg::frame_done_t done,
  output uwbrfp_pkg::drain_stat_t stat,
  output logic                    rd_en,
  output logic [5:0]              rd_addr,
  input  logic [7:0]              rd_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    status,
  output logic [1:0]              frame_kind,
  output logic [3:0]              field_id,
  output logic [63:0]             field_value,
  output logic                    last_of_frame
);

  logic        busy;
  logic        rd_valid;
  logic [5:0]  end_addr;
  logic [1:0]  kind;
  logic [3:0]  fidx;
  logic [2:0]  bidx;
  logic [63:0] acc;

  logic [3:0]  fsize;
  logic        last_byte;
  logic        last_field;
  logic        out_free;
  logic        consume;
  logic        adv;
  logic        issue_more;
  logic [63:0] base;
  logic [63:0] acc_next;
  logic [8:0]  end_wide;

  assign fsize = uwbrfp_pkg::field_size(kind, fidx);
  assign last_byte = ({1'b0, bidx} + 4'd1) == fsize;
  assign last_field = (fidx + 4'd1) == uwbrfp_pkg::field_count(kind);
  assign out_free = ~out_valid | ~out_stall;
  assign consume = rd_valid & (~last_byte | out_free);
  assign adv = ~rd_valid | consume;
  assign issue_more = busy & (rd_addr != end_addr);
  assign rd_en = issue_more & adv;
  assign end_wide = {1'b0, done.plen} + 9'd3;

  // Ranging fields are little-endian, tag fields big-endian.
  assign base = (bidx == 3'd0) ? 64'd0 : acc;
  assign acc_next = (kind == uwbrfp_pkg::KIND_RANGING) ?
                    (base | ({56'd0, rd_data} << {bidx, 3'b000})) :
                    {base[55:0], rd_data};

  assign stat.busy = busy;
  assign stat.out_block = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (done.valid && done.good) begin
        busy <= 1'b1;
        rd_valid <= 1'b0;
      end else begin
        if (adv) begin
          rd_valid <= rd_en;
        end
        if (consume && last_byte && last_field) begin
          busy <= 1'b0;
        end
      end
      if ((consume && last_byte) || (done.valid && !done.good)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid && done.good) begin
      rd_addr <= uwbrfp_pkg::PAYLOAD_START;
      end_addr <= end_wide[5:0];
      kind <= done.kind;
      fidx <= 4'd0;
      bidx <= 3'd0;
    end else begin
      if (rd_en) begin
        rd_addr <= rd_addr + 6'd1;
      end
      if (consume) begin
        if (last_byte) begin
          bidx <= 3'd0;
          fidx <= fidx + 4'd1;
        end else begin
          bidx <= bidx + 3'd1;
          acc <= acc_next;
        end
      end
    end
    if (done.valid && !done.good) begin
      status <= uwbrfp_pkg::STATUS_CSUM_ERR;
      frame_kind <= done.kind;
      field_id <= 4'd0;
      field_value <= 64'd0;
      last_of_frame <= 1'b1;
    end else if (consume && last_byte) begin
      status <= uwbrfp_pkg::STATUS_FIELD;
      frame_kind <= kind;
      field_id <= fidx;
      field_value <= acc_next;
      last_of_frame <= last_field;
    end
  end

endmodule

[hdl/uwb_report_frame_parser_unit.sv]
// Top level of the UWB report frame parser: framer, frame store and field
// drain. Depends on uwbrfp_pkg, uwbrfp_framer, uwbrfp_store, uwbrfp_drain.
//
//   Channel  Valid      Stall      Payload
//   input    in_valid   in_stall   rx_byte
//   output   out_valid  out_stall  status, frame_kind, field_id,
//                                  field_value, last_of_frame
//
// Bytes are taken one per cycle, back to back, while a frame is received and the drain is idle.
// After a good checksum the payload is read back from the store one byte per
// cycle while the output is not stalled, and the input stalls until the
// last field has been taken. The single store read port sets this
// pace.
// A checksum byte is stalled only while the result register is still full.
// Reset is synchronous; it returns the block to sync hunting and empties the
// result register. The store needs no clearing pass.
module uwb_report_frame_parser_unit #(
  parameter int MAX_FRAME_BYTES = uwbrfp_pkg::MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [1:0]  frame_kind,
  output logic [3:0]  field_id,
  output logic [63:0] field_value,
  output logic        last_of_frame
);

  uwbrfp_pkg::drain_stat_t stat;
  uwbrfp_pkg::store_wr_t   wr;
  uwbrfp_pkg::frame_done_t done;

  logic       rd_en;
  logic [5:0] rd_addr;
  logic [7:0] rd_data;

  // The framer tracks the byte position and the checksum of the frame and
  // writes every frame byte but the checksum into the store at its position.
  uwbrfp_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .stat     (stat),
    .wr       (wr),
    .done     (done)
  );

  uwbrfp_store #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The drain turns a good frame into one request per field, or a bad
  // checksum into a single error request.
  uwbrfp_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .stat          (stat),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .frame_kind    (frame_kind),
    .field_id      (field_id),
    .field_value   (field_value),
    .last_of_frame (last_of_frame)
  );

endmodule

[hdl/uwbrfp_checker.sv]
// Port checker for the UWB report frame parser and its bind statement.
// Depends on uwb_report_frame_parser_unit and uwbrfp_pkg.
module uwbrfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic [1:0]  frame_kind,
  input logic [3:0]  field_id,
  input logic [63:0] field_value,
  input logic        last_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_value) &&
    $stable(field_id) && $stable(status))
    else $error("stalled output request changed");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == uwbrfp_pkg::STATUS_CSUM_ERR |->
    last_of_frame && field_id == 4'd0 && field_value == 64'd0)
    else $error("checksum error request malformed");

  a_single_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == uwbrfp_pkg::STATUS_FIELD &&
    (frame_kind == uwbrfp_pkg::KIND_NEW_TAG || frame_kind == uwbrfp_pkg::KIND_DEL_TAG) |->
    last_of_frame && field_id == 4'd0 && field_value[63:0] == field_value)
    else $error("tag frame must carry one field");

  a_ranging_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == uwbrfp_pkg::STATUS_FIELD &&
    frame_kind == uwbrfp_pkg::KIND_RANGING |->
    (last_of_frame == (field_id == 4'd11)))
    else $error("ranging last flag out of place");

endmodule

bind uwb_report_frame_parser_unit uwbrfp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .frame_kind    (frame_kind),
  .field_id      (field_id),
  .field_value   (field_value),
  .last_of_frame (last_of_frame)
);
